// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the keyboard event port controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising edge outside of reset.
`define KBDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that cond is never true at a rising edge outside of reset.
`define KBDQ_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

// ----- rtl/core/kbdq_pkg.sv -----
// ----------------------------------------------------------------------------
// kbdq_pkg
// Types, codes and constants shared by the keyboard event port modules.
// ----------------------------------------------------------------------------
package kbdq_pkg;

	localparam int QUEUE_DEPTH_DEF = 10;

	localparam int DATA_W    = 32;
	localparam int CODE_W    = 30;
	localparam int ENTRY_W   = CODE_W + 1;
	localparam int AVAIL_BIT = 31;

	// mode codes
	localparam logic [1:0] MODE_KEY   = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;
	localparam logic [1:0] MODE_TICK  = 2'd3;

	// register select codes
	localparam logic SEL_CTRL = 1'b0;
	localparam logic SEL_KEY  = 1'b1;

	// control register bits
	localparam int CTRL_ENABLE_BIT = 0;

	typedef struct packed {
		logic [1:0]        mode;
		logic              reg_select;
		logic [DATA_W-1:0] write_data;
		logic [CODE_W-1:0] key_code;
		logic              key_down;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              irq_pulse;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_NONE      = 3'd0,
		OP_PUSH      = 3'd1,
		OP_RD_CTRL   = 3'd2,
		OP_CLR_AVAIL = 3'd3,
		OP_WR_CTRL   = 3'd4,
		OP_WR_KEY    = 3'd5,
		OP_TICK      = 3'd6,
		OP_POP       = 3'd7
	} dp_op_t;

	typedef struct packed {
		logic   load;     // update state and load the result register
		logic   rd_head;  // start a queue read at the head entry
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic enabled;
	} dp_sts_t;

endpackage

// ----- rtl/core/keyboard_event_fifo_port.sv -----
// ----------------------------------------------------------------------------
// keyboard_event_fifo_port
// Keyboard event port: control and key registers with a key event queue.
// ----------------------------------------------------------------------------
// Each request item is a key event, a bus read, a bus write or a refresh tick,
// and produces exactly one response item (read data and interrupt pulse).
// Key events with a nonzero code are queued while control bit 0 is set and
// the queue has room; queueing sets the interrupt pending flag. A read of the
// key register pops the oldest event into the key register (bit 31 avail,
// bits 30..1 code, bit 0 pressed) and pulses the interrupt if more remain;
// on an empty queue it clears the avail bit. A control write flushes the
// queue and clears the key register and pending flag. A tick pulses if the
// flag is pending and clears it. A key register read that pops an event
// goes through a pop state before it answers, because the queue storage
// is a RAM with a registered read port. A response waits in an output
// register, and the next request is taken in the cycle it is taken.
// Queue storage needs no clearing after reset.
// ----------------------------------------------------------------------------
module keyboard_event_fifo_port #(
	parameter int QUEUE_DEPTH = kbdq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  kbdq_pkg::in_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output kbdq_pkg::out_item_t rsp
);
	import kbdq_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Controller: decode each item, sequence the queue pop, own rsp_valid.
	kbdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: hold the queue, registers and the response register.
	kbdq_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.sts   (sts),
		.rsp   (rsp)
	);

endmodule

// ----- rtl/core/kbdq_ram.sv -----
// ----------------------------------------------------------------------------
// kbdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kbdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/kbdq_dp.sv -----
// ----------------------------------------------------------------------------
// kbdq_dp
// Datapath: event queue, registers, pending flag and result register.
// ----------------------------------------------------------------------------
module kbdq_dp #(
	parameter int QUEUE_DEPTH = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kbdq_pkg::in_item_t  req,
	input  kbdq_pkg::dp_cmd_t   cmd,
	output kbdq_pkg::dp_sts_t   sts,
	output kbdq_pkg::out_item_t rsp
);
	import kbdq_pkg::*;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [IDX_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic [DATA_W-1:0]  ctrl_q;
	logic [DATA_W-1:0]  key_q;
	logic               pending_q;
	out_item_t          rsp_q;

	logic [CNT_W:0]     tail_sum;
	logic [IDX_W-1:0]   tail;
	logic [IDX_W-1:0]   head_nxt;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [DATA_W-1:0]  key_popped;
	logic [DATA_W-1:0]  key_cleared;

	// tail = (head + count) mod depth, head below depth, count at most depth
	always_comb begin
		tail_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
		if (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
			tail = IDX_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH));
		end else begin
			tail = IDX_W'(tail_sum);
		end
		if (head_q == IDX_W'(QUEUE_DEPTH - 1)) begin
			head_nxt = '0;
		end else begin
			head_nxt = head_q + IDX_W'(1);
		end
	end

	kbdq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH),
		.ADDR_W(IDX_W)
	) u_queue (
		.clk  (clk),
		.we   (cmd.load && (cmd.op == OP_PUSH)),
		.waddr(tail),
		.wdata({req.key_code, req.key_down}),
		.re   (cmd.rd_head),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	assign key_popped  = {1'b1, ram_rdata};
	assign key_cleared = {1'b0, key_q[AVAIL_BIT-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			count_q   <= '0;
			ctrl_q    <= '0;
			key_q     <= '0;
			pending_q <= 1'b0;
		end else if (cmd.load) begin
			case (cmd.op)
				OP_PUSH: begin
					count_q   <= count_q + CNT_W'(1);
					pending_q <= 1'b1;
				end
				OP_POP: begin
					key_q   <= key_popped;
					head_q  <= head_nxt;
					count_q <= count_q - CNT_W'(1);
				end
				OP_CLR_AVAIL: begin
					key_q <= key_cleared;
				end
				OP_WR_CTRL: begin
					head_q    <= '0;
					count_q   <= '0;
					pending_q <= 1'b0;
					key_q     <= '0;
					ctrl_q    <= req.write_data;
				end
				OP_WR_KEY: begin
					key_q <= req.write_data;
				end
				OP_TICK: begin
					pending_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			case (cmd.op)
				OP_POP: begin
					rsp_q.read_data <= key_popped;
					rsp_q.irq_pulse <= (count_q != CNT_W'(1));
				end
				OP_CLR_AVAIL: begin
					rsp_q.read_data <= key_cleared;
					rsp_q.irq_pulse <= 1'b0;
				end
				OP_RD_CTRL: begin
					rsp_q.read_data <= ctrl_q;
					rsp_q.irq_pulse <= 1'b0;
				end
				OP_TICK: begin
					rsp_q.read_data <= '0;
					rsp_q.irq_pulse <= pending_q;
				end
				default: begin
					rsp_q.read_data <= '0;
					rsp_q.irq_pulse <= 1'b0;
				end
			endcase
		end
	end

	assign sts.empty   = (count_q == '0);
	assign sts.full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign sts.enabled = ctrl_q[CTRL_ENABLE_BIT];
	assign rsp         = rsp_q;

endmodule

// ----- rtl/core/kbdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// kbdq_ctrl
// Controller: item handshake, decode, pop sequencing, result valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kbdq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  kbdq_pkg::in_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  kbdq_pkg::dp_sts_t  sts,
	output kbdq_pkg::dp_cmd_t  cmd
);
	import kbdq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_POP  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   rsp_valid_q;
	logic   accept;

	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;

	always_comb begin
		state_nxt   = state_q;
		cmd.load    = 1'b0;
		cmd.rd_head = 1'b0;
		cmd.op      = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					case (req.mode)
						MODE_KEY: begin
							if ((req.key_code != '0) && sts.enabled && !sts.full) begin
								cmd.op = OP_PUSH;
							end
						end
						MODE_READ: begin
							if (req.reg_select == SEL_CTRL) begin
								cmd.op = OP_RD_CTRL;
							end else if (sts.empty) begin
								cmd.op = OP_CLR_AVAIL;
							end else begin
								// fetch head entry, finish next cycle
								cmd.load    = 1'b0;
								cmd.rd_head = 1'b1;
								state_nxt   = ST_POP;
							end
						end
						MODE_WRITE: begin
							cmd.op = (req.reg_select == SEL_CTRL) ? OP_WR_CTRL : OP_WR_KEY;
						end
						MODE_TICK: begin
							cmd.op = OP_TICK;
						end
						default: begin
							cmd.op = OP_NONE;
						end
					endcase
				end
			end
			ST_POP: begin
				cmd.load  = 1'b1;
				cmd.op    = OP_POP;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	`KBDQ_ASSERT(a_pop_completes, clk, arst_n, (state_q == ST_POP) |=> ((state_q == ST_IDLE) && rsp_valid_q), "pop did not complete in one cycle")
	`KBDQ_NEVER(a_rd_empty, clk, arst_n, cmd.rd_head && sts.empty, "queue read issued while empty")
	`KBDQ_NEVER(a_rsp_overwrite, clk, arst_n, cmd.load && rsp_valid_q && !rsp_ready, "result register overwritten before taken")

endmodule

// ----- test/keyboard_event_fifo_port_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyboard_event_fifo_port_tb
// Self-checking bench for the keyboard event port. Requests go in as key
// events, bus reads, bus writes and refresh ticks. An in-bench copy of the
// port state predicts each response, and a monitor compares every response
// with the oldest prediction. A directed opening covers reset values, key
// filtering, a full queue and register writes. Random traffic follows under
// three sender/receiver stall mixes.
// ----------------------------------------------------------------------------
module keyboard_event_fifo_port_tb;
	import kbdq_pkg::*;

	localparam int QDEPTH      = QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 8;   // settle time once nothing is pending
	localparam int PRINT_LIMIT = 20;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	in_item_t  req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	out_item_t rsp;

	keyboard_event_fifo_port #(
		.QUEUE_DEPTH(QDEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// Port state as the bench sees it: queued entries are {code, pressed}.
	logic [ENTRY_W-1:0] ev_store [QDEPTH];
	int                 ev_head;
	int                 ev_count;
	logic [DATA_W-1:0]  ctrl_reg;
	logic [DATA_W-1:0]  key_reg;
	logic               irq_flag;
	logic               key_dropped;   // last key event was ignored

	// Predicted responses, oldest first.
	out_item_t port_rsp_q [$];

	int send_idle_pct;
	int recv_idle_pct;
	int mismatches;
	int cycle_count;
	int useful_items;
	int items_sent;
	int pops_seen;
	int pulses_seen;
	int full_drops;

	// Clock: 10 ns period.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_count, port_rsp_q.size());
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: stall the response channel at the current rate.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	// Advance the port state by one accepted item and return its response.
	function automatic out_item_t model_port_access(input in_item_t it);
		out_item_t res;
		int        tail;
		res         = '0;
		key_dropped = 1'b0;
		case (it.mode)
			MODE_KEY: begin
				if (it.key_code != '0 && ctrl_reg[CTRL_ENABLE_BIT] && ev_count < QDEPTH) begin
					tail           = (ev_head + ev_count) % QDEPTH;
					ev_store[tail] = {it.key_code, it.key_down};
					ev_count++;
					irq_flag = 1'b1;
				end else begin
					key_dropped = 1'b1;
					if (it.key_code != '0 && ctrl_reg[CTRL_ENABLE_BIT])
						full_drops++;
				end
			end
			MODE_READ: begin
				if (it.reg_select == SEL_CTRL) begin
					res.read_data = ctrl_reg;
				end else begin
					if (ev_count > 0) begin
						key_reg = {1'b1, ev_store[ev_head]};
						ev_head = (ev_head + 1) % QDEPTH;
						ev_count--;
						res.irq_pulse = (ev_count > 0);
						pops_seen++;
					end else begin
						key_reg[AVAIL_BIT] = 1'b0;
					end
					res.read_data = key_reg;
				end
			end
			MODE_WRITE: begin
				if (it.reg_select == SEL_CTRL) begin
					ev_head  = 0;
					ev_count = 0;
					irq_flag = 1'b0;
					key_reg  = '0;
					ctrl_reg = it.write_data;
				end else begin
					key_reg = it.write_data;
				end
			end
			default: begin
				res.irq_pulse = irq_flag;
				irq_flag      = 1'b0;
			end
		endcase
		return res;
	endfunction

	function automatic in_item_t mk_item(input logic [1:0] mode, input logic sel,
		input logic [DATA_W-1:0] wdata, input logic [CODE_W-1:0] code, input logic dn);
		in_item_t it;
		it.mode       = mode;
		it.reg_select = sel;
		it.write_data = wdata;
		it.key_code   = code;
		it.key_down   = dn;
		return it;
	endfunction

	// Send one item. Call right after a rising edge; returns at the edge that
	// accepted it, with valid still high so a following item can go back to back.
	task automatic send_item(input in_item_t it);
		out_item_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		do @(posedge clk); while (!req_ready);
		// Accepted at this edge: predict now, before the next item goes in.
		res = model_port_access(it);
		port_rsp_q.push_back(res);
		items_sent++;
		if (res.irq_pulse)
			pulses_seen++;
		if (!key_dropped)
			useful_items++;
	endtask

	// Hold the sender off until every predicted response has come back.
	task automatic drain_responses();
		req_valid <= 1'b0;
		while (port_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	// Monitor: compare each accepted response with the oldest prediction.
	always @(posedge clk) begin : check_rsp
		out_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (port_rsp_q.size() == 0) begin
				report_mismatch($sformatf("response %h with nothing pending", rsp));
			end else begin
				want = port_rsp_q.pop_front();
				if (rsp.read_data !== want.read_data)
					report_mismatch($sformatf("read_data %h, predicted %h",
						rsp.read_data, want.read_data));
				if (rsp.irq_pulse !== want.irq_pulse)
					report_mismatch($sformatf("irq_pulse %b, predicted %b",
						rsp.irq_pulse, want.irq_pulse));
			end
		end
	end

	// Registers read back as zero, empty key read, tick with nothing pending.
	task automatic test_reset_state();
		send_item(mk_item(MODE_READ, SEL_CTRL, $urandom, CODE_W'($urandom), 1'b1));
		send_item(mk_item(MODE_READ, SEL_KEY, $urandom, CODE_W'($urandom), 1'b0));
		send_item(mk_item(MODE_TICK, SEL_KEY, $urandom, CODE_W'($urandom), 1'b1));
	endtask

	// Drop key events while disabled and events with the unsupported code.
	task automatic test_key_filtering();
		send_item(mk_item(MODE_KEY, SEL_CTRL, $urandom, 30'd5, 1'b1));
		send_item(mk_item(MODE_WRITE, SEL_CTRL, 32'hFFFF_FFFF, CODE_W'($urandom), 1'b0));
		send_item(mk_item(MODE_READ, SEL_CTRL, $urandom, CODE_W'($urandom), 1'b0));
		send_item(mk_item(MODE_KEY, SEL_KEY, $urandom, '0, 1'b1));
	endtask

	// Fill the queue past its depth, tick twice, then pop with more remaining.
	task automatic test_queue_limits();
		logic [CODE_W-1:0] code;
		for (int i = 0; i <= QDEPTH; i++) begin
			if (i == 0)
				code = '1;
			else if (i == QDEPTH)
				code = 30'h2AAA_AAAA;   // lands on a full queue
			else
				code = CODE_W'(i);
			send_item(mk_item(MODE_KEY, SEL_KEY, $urandom, code, (i % 2) == 0));
		end
		send_item(mk_item(MODE_TICK, SEL_CTRL, $urandom, CODE_W'($urandom), 1'b0));
		send_item(mk_item(MODE_TICK, SEL_KEY, $urandom, CODE_W'($urandom), 1'b1));
		send_item(mk_item(MODE_READ, SEL_KEY, $urandom, CODE_W'($urandom), 1'b0));
	endtask

	// Flush through a control write, then write and read the key register.
	task automatic test_register_writes();
		send_item(mk_item(MODE_WRITE, SEL_CTRL, 32'h0000_0000, CODE_W'($urandom), 1'b1));
		send_item(mk_item(MODE_READ, SEL_KEY, $urandom, CODE_W'($urandom), 1'b1));
		send_item(mk_item(MODE_WRITE, SEL_KEY, 32'hFFFF_FFFF, CODE_W'($urandom), 1'b0));
		send_item(mk_item(MODE_READ, SEL_KEY, $urandom, CODE_W'($urandom), 1'b0));
	endtask

	// Random traffic until target more items have gone in. Most items follow
	// the push/pop pattern of real use; now and then a full burst of events
	// is pushed and read back, so full-queue drops and multi-pop runs happen.
	task automatic test_random_traffic(input int target);
		in_item_t it;
		int       r;
		int       goal;
		goal = items_sent + target;
		while (items_sent < goal) begin
			if ($urandom_range(0, 24) == 0) begin
				for (int i = 0; i <= QDEPTH; i++)
					send_item(mk_item(MODE_KEY, 1'($urandom), $urandom,
						CODE_W'($urandom_range(1, 32'h3FFF_FFFF)), 1'($urandom)));
				for (int i = 0; i <= QDEPTH; i++)
					send_item(mk_item(MODE_READ, SEL_KEY, $urandom, CODE_W'($urandom),
						1'($urandom)));
			end else begin
				// Unused fields stay random.
				it = mk_item(MODE_KEY, 1'($urandom), $urandom, CODE_W'($urandom),
					1'($urandom));
				r  = $urandom_range(0, 99);
				if (r < 40) begin
					case ($urandom_range(0, 19))
						0:       it.key_code = '0;
						1:       it.key_code = CODE_W'(1);
						2:       it.key_code = '1;
						default: ;
					endcase
				end else if (r < 70) begin
					it.mode       = MODE_READ;
					it.reg_select = ($urandom_range(0, 4) != 0) ? SEL_KEY : SEL_CTRL;
				end else if (r < 84) begin
					it.mode = MODE_TICK;
				end else if (r < 92) begin
					it.mode       = MODE_WRITE;
					it.reg_select = SEL_KEY;
				end else begin
					// Control write: mostly keep the port enabled.
					it.mode       = MODE_WRITE;
					it.reg_select = SEL_CTRL;
					it.write_data[CTRL_ENABLE_BIT] = ($urandom_range(0, 4) != 0);
				end
				send_item(it);
			end
		end
	endtask

	initial begin
		ev_head       = 0;
		ev_count      = 0;
		ctrl_reg      = '0;
		key_reg       = '0;
		irq_flag      = 1'b0;
		key_dropped   = 1'b0;
		useful_items  = 0;
		items_sent    = 0;
		pops_seen     = 0;
		pulses_seen   = 0;
		full_drops    = 0;
		send_idle_pct = 12;
		recv_idle_pct = 54;

		// Hold reset, then release it on an edge.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_key_filtering();
		test_queue_limits();
		test_register_writes();

		test_random_traffic(320);
		drain_responses();

		send_idle_pct = 54;
		recv_idle_pct = 12;
		test_random_traffic(320);
		drain_responses();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(310);
		drain_responses();

		// Let any stray response show up before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d effective items: %0d pops, %0d irq pulses, %0d full-queue drops",
			useful_items, pops_seen, pulses_seen, full_drops);
		$display("ran %0d cycles under three stall mixes, %0d mismatches",
			cycle_count, mismatches);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/kbdq_pkg.sv
rtl/core/kbdq_ram.sv
rtl/core/kbdq_dp.sv
rtl/core/kbdq_ctrl.sv
rtl/core/keyboard_event_fifo_port.sv
test/keyboard_event_fifo_port_tb.sv
